### design/nghri_pkg.sv
// Package for the n-gram hash row indexer: sizes, operation codes and
// the command and status structs between controller and datapath.
// Depends on nothing.
package nghri_pkg;
    localparam int MAX_GRAM   = 4;
    localparam int MAX_HEADS  = 8;
    localparam int TOKEN_BITS = 20;
    localparam int HIST_DEPTH = MAX_GRAM - 1;
    localparam int MULT_IDX_W = $clog2(MAX_GRAM);
    localparam int HEAD_IDX_W = $clog2(MAX_HEADS);
    localparam int CNT_W      = $clog2(MAX_GRAM);

    localparam logic [1:0] OP_TOKEN  = 2'd0;
    localparam logic [1:0] OP_MULT   = 2'd1;
    localparam logic [1:0] OP_SIZE   = 2'd2;
    localparam logic [1:0] OP_OFFSET = 2'd3;

    localparam logic [1:0] CFG_END_TOKEN = 2'd0;
    localparam logic [1:0] CFG_GRAM_LEN  = 2'd1;
    localparam logic [1:0] CFG_HEADS     = 2'd2;

    typedef struct packed {
        logic                  load_token;
        logic                  clear_mix;
        logic                  mix_step;
        logic [MULT_IDX_W-1:0] mix_q;
        logic                  div_start;
        logic [HEAD_IDX_W-1:0] head;
        logic                  out_load;
        logic                  last;
        logic                  bad;
        logic                  commit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_busy;
    } t_status;
endpackage

### design/nghri_datapath.sv
// Datapath of the n-gram hash row indexer: tables, history, mix unit,
// bit-serial remainder unit and output register. Uses nghri_pkg.
module nghri_datapath import nghri_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic [1:0]            i_operation,
    input  logic [2:0]            i_table_slot,
    input  logic [63:0]           i_table_word,
    input  logic                  i_table_we,
    input  logic [TOKEN_BITS-1:0] i_token_id,
    input  logic                  i_starts_sequence,
    input  logic [19:0]           i_end_token,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [2:0]            o_head_number,
    output logic [39:0]           o_row_index,
    output logic                  o_last_of_token,
    output logic                  o_bad_setup
);
    logic [63:0]           r_mult [MAX_GRAM];
    logic [31:0]           r_size [MAX_HEADS];
    logic [39:0]           r_offs [MAX_HEADS];
    logic [TOKEN_BITS-1:0] r_hist [HIST_DEPTH];
    logic [CNT_W-1:0]      r_since;
    logic [TOKEN_BITS-1:0] r_tok;
    logic                  r_start;
    logic [63:0]           r_mix;
    logic [63:0]           r_prod;
    logic [63:0]           r_mag;
    logic                  r_neg;
    logic [31:0]           r_dsize;
    logic [32:0]           r_rem;
    logic [6:0]            r_bit;
    logic                  r_busy;
    logic                  r_done;
    logic                  r_ovalid;
    logic [2:0]            r_ohead;
    logic [39:0]           r_orow;
    logic                  r_olast;
    logic                  r_obad;
    logic [TOKEN_BITS-1:0] w_eos;
    logic [TOKEN_BITS-1:0] w_tsel;
    logic [32:0]           w_shift;
    logic [32:0]           w_diff;
    logic [31:0]           w_res;
    logic [63:0]           w_mix;

    assign w_eos = i_end_token[TOKEN_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_table_we) begin
            unique case (i_operation)
                OP_MULT:   if (32'(i_table_slot) < MAX_GRAM)
                    r_mult[i_table_slot[MULT_IDX_W-1:0]] <= i_table_word;
                OP_SIZE:   if (32'(i_table_slot) < MAX_HEADS)
                    r_size[i_table_slot[HEAD_IDX_W-1:0]] <= i_table_word[31:0];
                OP_OFFSET: if (32'(i_table_slot) < MAX_HEADS)
                    r_offs[i_table_slot[HEAD_IDX_W-1:0]] <= i_table_word[39:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_tsel = w_eos;
        if (i_cmd.mix_q == '0) begin
            w_tsel = r_tok;
        end else if (!r_start && (CNT_W'(i_cmd.mix_q) <= r_since)) begin
            w_tsel = r_hist[i_cmd.mix_q - MULT_IDX_W'(1)];
        end
    end

    // The last product of an order is still in r_prod when the remainder starts.
    assign w_mix = r_mix ^ r_prod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_token) begin
            r_tok   <= i_token_id;
            r_start <= i_starts_sequence;
        end
        if (i_cmd.clear_mix) begin
            r_mix  <= '0;
            r_prod <= '0;
        end else if (i_cmd.mix_step) begin
            r_prod <= 64'(w_tsel) * r_mult[i_cmd.mix_q];
            r_mix  <= r_mix ^ r_prod;
        end else begin
            r_mix  <= r_mix ^ r_prod;
            r_prod <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since <= '0;
            for (int i = 0; i < HIST_DEPTH; i++) r_hist[i] <= '0;
        end else if (i_cmd.commit) begin
            for (int i = HIST_DEPTH - 1; i > 0; i--)
                r_hist[i] <= r_start ? TOKEN_BITS'(0) : r_hist[i-1];
            r_hist[0] <= r_tok;
            if (r_tok == w_eos) begin
                r_since <= '0;
            end else if (r_start) begin
                r_since <= CNT_W'(1);
            end else if (32'(r_since) < HIST_DEPTH) begin
                r_since <= r_since + CNT_W'(1);
            end
        end
    end

    assign w_shift = {r_rem[31:0], r_mag[63]};
    assign w_diff  = w_shift - {1'b0, r_dsize};

    always_comb begin
        w_res = r_rem[31:0];
        if (r_dsize == '0) begin
            w_res = '0;
        end else if (r_neg && r_rem[31:0] != '0) begin
            w_res = r_dsize - r_rem[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
            r_neg   <= w_mix[63];
            r_mag   <= w_mix[63] ? (~w_mix + 64'd1) : w_mix;
            r_dsize <= r_size[i_cmd.head];
            r_rem   <= '0;
            r_bit   <= 7'd64;
        end else if (r_busy) begin
            r_mag <= {r_mag[62:0], 1'b0};
            r_rem <= w_diff[32] ? w_shift : w_diff;
            r_bit <= r_bit - 7'd1;
            if (r_bit == 7'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
            r_ohead  <= i_cmd.bad ? 3'd0 : 3'(i_cmd.head);
            r_orow   <= i_cmd.bad ? 40'd0 : 40'(w_res) + r_offs[i_cmd.head];
            r_olast  <= i_cmd.last;
            r_obad   <= i_cmd.bad;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_status.div_done = r_done;
    assign o_status.out_busy = r_ovalid && !i_out_ready;
    assign o_out_valid     = r_ovalid;
    assign o_head_number   = r_ohead;
    assign o_row_index     = r_orow;
    assign o_last_of_token = r_olast;
    assign o_bad_setup     = r_obad;
endmodule

### design/nghri_ctrl.sv
// Controller of the n-gram hash row indexer: steps orders, mix terms and
// heads, and sequences the remainder unit. Uses nghri_pkg.
module nghri_ctrl import nghri_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_operation,
    input  logic [2:0] i_gram_length,
    input  logic [3:0] i_heads_per_order,
    input  t_status    i_status,
    output t_cmd       o_cmd,
    output logic       o_table_we
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MIX  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam logic [2:0] S_BAD  = 3'd5;
    localparam logic [2:0] S_END  = 3'd6;

    logic [2:0]            r_state, n_state;
    logic [3:0]            r_p, n_p;
    logic [3:0]            r_q, n_q;
    logic [3:0]            r_h, n_h;
    logic [HEAD_IDX_W-1:0] r_head, n_head;
    logic [7:0]            w_total;
    logic                  w_none;
    logic                  w_bad;
    logic                  w_acc;

    assign w_total = 8'(i_gram_length - 3'd1) * 8'(i_heads_per_order);
    assign w_none  = (i_gram_length < 3'd2) || (i_heads_per_order == 4'd0);
    assign w_bad   = (32'(w_total) > MAX_HEADS) || (32'(i_gram_length) > MAX_GRAM);
    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc   = i_in_valid && o_in_ready;
    assign o_table_we = w_acc && (i_operation != OP_TOKEN);

    always_comb begin
        n_state = r_state;
        n_p = r_p;
        n_q = r_q;
        n_h = r_h;
        n_head = r_head;
        o_cmd = '0;
        o_cmd.head  = r_head;
        o_cmd.mix_q = r_q[MULT_IDX_W-1:0];
        unique case (r_state)
            S_IDLE: if (w_acc && i_operation == OP_TOKEN) begin
                o_cmd.load_token = 1'b1;
                o_cmd.clear_mix  = 1'b1;
                n_p = 4'd1;
                n_q = 4'd0;
                n_h = 4'd0;
                n_head = '0;
                priority if (w_none) n_state = S_END;
                else if (w_bad) n_state = S_BAD;
                else n_state = S_MIX;
            end
            S_MIX: begin
                o_cmd.mix_step = 1'b1;
                if (r_q == r_p) begin
                    n_state = S_DIV;
                end else begin
                    n_q = r_q + 4'd1;
                end
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: if (i_status.div_done) n_state = S_OUT;
            S_OUT: if (!i_status.out_busy) begin
                o_cmd.out_load = 1'b1;
                o_cmd.last = (8'(r_head) + 8'd1 == w_total);
                n_head = r_head + HEAD_IDX_W'(1);
                priority if (8'(r_head) + 8'd1 == w_total) begin
                    n_state = S_END;
                end else if (r_h + 4'd1 == i_heads_per_order) begin
                    n_h = 4'd0;
                    n_p = r_p + 4'd1;
                    n_q = 4'd0;
                    o_cmd.clear_mix = 1'b1;
                    n_state = S_MIX;
                end else begin
                    n_h = r_h + 4'd1;
                    n_state = S_DIV;
                end
            end
            S_BAD: if (!i_status.out_busy) begin
                o_cmd.out_load = 1'b1;
                o_cmd.last = 1'b1;
                o_cmd.bad  = 1'b1;
                n_state = S_END;
            end
            S_END: begin
                o_cmd.commit = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_p <= '0;
            r_q <= '0;
            r_h <= '0;
            r_head <= '0;
        end else begin
            r_state <= n_state;
            r_p <= n_p;
            r_q <= n_q;
            r_h <= n_h;
            r_head <= n_head;
        end
    end
endmodule

### design/ngram_hash_row_indexer.sv
// Top level of the n-gram hash row indexer: configuration registers,
// controller and datapath. Uses nghri_pkg, nghri_ctrl and nghri_datapath.
// Usage: an input request carries an operation. Table writes (multiplier,
// head size, head offset) are written directly and give no result.
// A token request gives one result request per head, in head order, the
// last one marked; a bad head setup gives a single error result instead.
// Configuration writes (end token, gram length, heads per order) use their
// own channel, always ready; they are to be made only while the block is idle, which the block does not enforce.
// Timing: each head's result comes from the bit-serial 64-step remainder
// unit shared by all heads, after the mixing of its order. One token is
// worked on at a time; input ready is high only between tokens.
// Reset clears the history, the controller and the output valid flag and
// loads the configuration defaults; the tables hold nothing until written.
// If the receiver stalls, the output register holds its result and the
// controller waits before loading the next one.
module ngram_hash_row_indexer import nghri_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_operation,
    input  logic [2:0]            i_table_slot,
    input  logic [63:0]           i_table_word,
    input  logic [TOKEN_BITS-1:0] i_token_id,
    input  logic                  i_starts_sequence,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [19:0]           i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_head_number,
    output logic [39:0]           o_row_index,
    output logic                  o_last_of_token,
    output logic                  o_bad_setup
);
    logic [19:0] r_end_token;
    logic [2:0]  r_gram_length;
    logic [3:0]  r_heads;
    t_cmd        w_cmd;
    t_status     w_status;
    logic        w_table_we;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_token   <= '0;
            r_gram_length <= 3'd3;
            r_heads       <= 4'd2;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_END_TOKEN: r_end_token   <= i_cfg_data;
                CFG_GRAM_LEN:  r_gram_length <= i_cfg_data[2:0];
                CFG_HEADS:     r_heads       <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    nghri_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_operation       (i_operation),
        .i_gram_length     (r_gram_length),
        .i_heads_per_order (r_heads),
        .i_status          (w_status),
        .o_cmd             (w_cmd),
        .o_table_we        (w_table_we)
    );

    nghri_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_operation       (i_operation),
        .i_table_slot      (i_table_slot),
        .i_table_word      (i_table_word),
        .i_table_we        (w_table_we),
        .i_token_id        (i_token_id),
        .i_starts_sequence (i_starts_sequence),
        .i_end_token       (r_end_token),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_head_number     (o_head_number),
        .o_row_index       (o_row_index),
        .o_last_of_token   (o_last_of_token),
        .o_bad_setup       (o_bad_setup)
    );
endmodule
